// ===== rtl/touch_stroke_smoother_unit_macros.svh =====
// assertion macros for the touch stroke smoother checker
`ifndef TOUCH_STROKE_SMOOTHER_UNIT_MACROS_SVH
`define TOUCH_STROKE_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define TSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsm_pkg.sv =====
// types, constants and helpers shared by the touch stroke smoother
package tsm_pkg;

    localparam int COORD_W     = 16;
    // quotient width: covers 44 * 32768 for smoothing sums
    localparam int DIV_W       = 21;
    localparam int DEN_W       = 6;
    localparam int SUM_W       = DIV_W + 1;
    localparam int D2_W        = 34;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [D2_W-1:0] SPLIT_D2 = D2_W'(100 * 256);

    typedef enum logic [1:0] {
        REQ_DOWN   = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_MOVE   = 2'd2,
        REQ_UP     = 2'd3
    } req_t;

    typedef struct packed {
        req_t                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_pop_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] divisor;
        logic [DIV_W-1:0] num_x;
        logic [DIV_W-1:0] num_y;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo_x;
        logic [DIV_W-1:0] quo_y;
    } div_rsp_t;

    // neighbour weights in eighths by distance
    function automatic logic [3:0] tap_weight(input logic [1:0] span);
        logic [3:0] w;
        case (span)
            2'd0:    w = 4'd8;
            2'd1:    w = 4'd7;
            2'd2:    w = 4'd6;
            default: w = 4'd5;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tsm_if.sv =====
// stream interfaces for touch requests and stroke points
interface tsm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;

    modport source(output valid, req_type, in_x, in_y, input ready);
    modport sink(input valid, req_type, in_x, in_y, output ready);
    modport mon(input valid, ready, req_type, in_x, in_y);
endinterface

interface tsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               stroke_end;
    logic               last;

    modport source(output valid, out_x, out_y, stroke_end, last, input ready);
    modport sink(input valid, out_x, out_y, stroke_end, last, output ready);
    modport mon(input valid, ready, out_x, out_y, stroke_end, last);
endinterface

// ===== rtl/tsm_front.sv =====
// request intake: tracks the stroke and drops moves outside one
module tsm_front import tsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    tsm_in_if.sink  touch,
    output q_push_t push,
    input  logic    full
);

    logic active_reg;
    logic active_next;
    logic accept;
    req_t req;

    assign touch.ready = !full;
    assign accept      = touch.valid && !full;
    assign req         = req_t'(touch.req_type);

    always_comb
    begin
        active_next  = active_reg;
        push.push    = 1'b0;
        push.cmd.op  = req;
        push.cmd.x   = touch.in_x;
        push.cmd.y   = touch.in_y;
        if (accept)
        begin
            case (req)
                REQ_DOWN:
                begin
                    active_next = 1'b1;
                    push.push   = 1'b1;
                end
                REQ_CANCEL:
                begin
                    active_next = 1'b0;
                    push.push   = 1'b1;
                end
                REQ_MOVE:
                begin
                    push.push = active_reg;
                end
                REQ_UP:
                begin
                    active_next = 1'b0;
                    push.push   = 1'b1;
                end
                default:
                begin
                    push.push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/tsm_queue.sv =====
// short command queue between intake and execution
module tsm_queue import tsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    output logic    full,
    output q_pop_t  head,
    input  logic    take
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = take && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ===== rtl/tsm_divider.sv =====
// two-lane restoring divider, one quotient bit per cycle
module tsm_divider import tsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] numx_reg, numx_next;
    logic [DIV_W-1:0] numy_reg, numy_next;
    logic [DEN_W-1:0] remx_reg, remx_next;
    logic [DEN_W-1:0] remy_reg, remy_next;
    logic [DEN_W:0]   trial_x, trial_y;
    logic [DEN_W:0]   diff_x, diff_y;
    logic             ge_x, ge_y;

    assign trial_x = {remx_reg, numx_reg[DIV_W-1]};
    assign trial_y = {remy_reg, numy_reg[DIV_W-1]};
    assign ge_x    = trial_x >= {1'b0, div_reg};
    assign ge_y    = trial_y >= {1'b0, div_reg};
    assign diff_x  = trial_x - {1'b0, div_reg};
    assign diff_y  = trial_y - {1'b0, div_reg};

    assign rsp.done  = done_reg;
    assign rsp.quo_x = numx_reg;
    assign rsp.quo_y = numy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        numx_next = numx_reg;
        numy_next = numy_reg;
        remx_next = remx_reg;
        remy_next = remy_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            div_next  = req.divisor;
            numx_next = req.num_x;
            numy_next = req.num_y;
            remx_next = '0;
            remy_next = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where the dividend shifts out
            remx_next = ge_x ? diff_x[DEN_W-1:0] : trial_x[DEN_W-1:0];
            remy_next = ge_y ? diff_y[DEN_W-1:0] : trial_y[DEN_W-1:0];
            numx_next = {numx_reg[DIV_W-2:0], ge_x};
            numy_next = {numy_reg[DIV_W-2:0], ge_y};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
    end

endmodule

// ===== rtl/tsm_back.sv =====
// execution: point window, segment split, smoothing and point output
module tsm_back import tsm_pkg::*;
#(
    parameter int WINDOW_POINTS = 8,
    parameter int MAX_SEGMENTS  = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_pop_t    head,
    output logic      take,
    output div_req_t  dreq,
    input  div_rsp_t  drsp,
    tsm_out_if.source point
);

    localparam int WP = WINDOW_POINTS;
    localparam int IW = $clog2(WP);
    localparam int HW = $clog2(WP + 1);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_FLUSH   = 15'b000000000000010,
        S_APPEND  = 15'b000000000000100,
        S_LOAD    = 15'b000000000001000,
        S_SQX     = 15'b000000000010000,
        S_SQY     = 15'b000000000100000,
        S_DECIDE  = 15'b000000001000000,
        S_SEGDIV  = 15'b000000010000000,
        S_SEGWAIT = 15'b000000100000000,
        S_SEGNEXT = 15'b000001000000000,
        S_SMSTART = 15'b000010000000000,
        S_SMTAP   = 15'b000100000000000,
        S_SMDIV   = 15'b001000000000000,
        S_SMWAIT  = 15'b010000000000000,
        S_SMCOPY  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ap_ret_reg, ap_ret_next;

    logic signed [COORD_W-1:0] win_x_reg [WP];
    logic signed [COORD_W-1:0] win_y_reg [WP];
    logic signed [COORD_W-1:0] win_x_next [WP];
    logic signed [COORD_W-1:0] win_y_next [WP];
    logic signed [COORD_W-1:0] sm_x_reg [WP];
    logic signed [COORD_W-1:0] sm_y_reg [WP];
    logic signed [COORD_W-1:0] sm_x_next [WP];
    logic signed [COORD_W-1:0] sm_y_next [WP];

    logic [HW-1:0] held_reg, held_next;
    logic          committed_reg, committed_next;
    logic [IW-1:0] fl_idx_reg, fl_idx_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] seg_i_reg, seg_i_next;
    logic [IW-1:0] sm_i_reg, sm_i_next;
    logic [IW-1:0] tap_reg, tap_next;

    req_t                      op_reg, op_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [COORD_W:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [D2_W-1:0]           d2_reg, d2_next;
    logic [DIV_W-1:0]          accx_reg, accx_next, accy_reg, accy_next;
    logic signed [COORD_W-1:0] ap_x_reg, ap_x_next, ap_y_reg, ap_y_next;
    logic                      ap_final_reg, ap_final_next;
    logic signed [SUM_W-1:0]   sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [DEN_W-1:0]          den_reg, den_next;

    logic                      ov_reg, ov_next;
    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic                      oend_reg, olast_reg;

    logic                      out_free;
    logic                      emit;
    logic signed [COORD_W-1:0] emit_x, emit_y;
    logic                      emit_end, emit_last;

    logic [IW-1:0]             rd_addr;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic [HW-1:0]             held_m1, held_m2;
    logic [IW-1:0]             last_ix, prev_ix;
    logic                      flush_end;

    logic signed [D2_W-1:0]    mul_a;
    logic signed [2*COORD_W+1:0] mul_p;
    logic [CW-1:0]             c_calc;
    logic [COORD_W:0]          mdx, mdy;
    logic [COORD_W-1:0]        seg_x, seg_y;

    logic [IW:0]               ip3;
    logic [IW-1:0]             tap_end;
    logic [IW-1:0]             dist_full;
    logic [3:0]                w;
    logic signed [SUM_W-1:0]   w_s, rdx_e, rdy_e;
    logic [SUM_W-1:0]          negsum_x, negsum_y;
    logic [DIV_W-1:0]          vx, vy, nvx, nvy;
    logic [COORD_W-1:0]        smv_x, smv_y;

    assign out_free         = !ov_reg || point.ready;
    assign point.valid      = ov_reg;
    assign point.out_x      = ox_reg;
    assign point.out_y      = oy_reg;
    assign point.stroke_end = oend_reg;
    assign point.last       = olast_reg;

    assign held_m1   = held_reg - HW'(1);
    assign held_m2   = held_reg - HW'(2);
    assign last_ix   = held_m1[IW-1:0];
    assign prev_ix   = held_m2[IW-1:0];
    assign flush_end = (HW'(fl_idx_reg) == held_m1);

    // one window read port, shared by flush, split and smoothing
    always_comb
    begin
        case (state_reg)
            S_FLUSH: rd_addr = fl_idx_reg;
            S_LOAD:  rd_addr = prev_ix;
            S_SMTAP: rd_addr = tap_reg;
            default: rd_addr = '0;
        endcase
    end

    assign rd_x = win_x_reg[rd_addr];
    assign rd_y = win_y_reg[rd_addr];

    // squared distance, one term per cycle
    assign mul_p = $signed(mul_a[COORD_W:0]) * $signed(mul_a[COORD_W:0]);

    always_comb
    begin
        c_calc = CW'(2);
        for (int j = 3; j <= MAX_SEGMENTS; j++)
        begin
            if (d2_reg >= D2_W'(25 * j * j * 256))
            begin
                c_calc = c_calc + 1'b1;
            end
        end
    end

    assign mdx   = dx_reg[COORD_W] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
    assign mdy   = dy_reg[COORD_W] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
    assign seg_x = x0_reg + (dx_reg[COORD_W] ? (COORD_W'(0) - drsp.quo_x[COORD_W-1:0])
                                             : drsp.quo_x[COORD_W-1:0]);
    assign seg_y = y0_reg + (dy_reg[COORD_W] ? (COORD_W'(0) - drsp.quo_y[COORD_W-1:0])
                                             : drsp.quo_y[COORD_W-1:0]);

    // smoothing taps: neighbours within three, clipped at the window edge
    assign ip3       = {1'b0, sm_i_reg} + (IW + 1)'(3);
    assign tap_end   = (ip3 >= (IW + 1)'(WP - 1)) ? IW'(WP - 1) : ip3[IW-1:0];
    assign dist_full = (tap_reg >= sm_i_reg) ? (tap_reg - sm_i_reg) : (sm_i_reg - tap_reg);
    assign w         = tap_weight(dist_full[1:0]);
    assign w_s       = $signed({{(SUM_W - 4){1'b0}}, w});
    assign rdx_e     = SUM_W'(rd_x);
    assign rdy_e     = SUM_W'(rd_y);
    assign negsum_x  = -sumx_reg;
    assign negsum_y  = -sumy_reg;

    // truncate to whole pixels, sign restored afterwards
    assign vx    = {drsp.quo_x[DIV_W-1:4], 4'b0000};
    assign vy    = {drsp.quo_y[DIV_W-1:4], 4'b0000};
    assign nvx   = -vx;
    assign nvy   = -vy;
    assign smv_x = sumx_reg[SUM_W-1] ? nvx[COORD_W-1:0] : vx[COORD_W-1:0];
    assign smv_y = sumy_reg[SUM_W-1] ? nvy[COORD_W-1:0] : vy[COORD_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ap_ret_next    = ap_ret_reg;
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        sm_x_next      = sm_x_reg;
        sm_y_next      = sm_y_reg;
        held_next      = held_reg;
        committed_next = committed_reg;
        fl_idx_next    = fl_idx_reg;
        c_next         = c_reg;
        seg_i_next     = seg_i_reg;
        sm_i_next      = sm_i_reg;
        tap_next       = tap_reg;
        op_next        = op_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        d2_next        = d2_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        ap_x_next      = ap_x_reg;
        ap_y_next      = ap_y_reg;
        ap_final_next  = ap_final_reg;
        sumx_next      = sumx_reg;
        sumy_next      = sumy_reg;
        den_next       = den_reg;
        take           = 1'b0;
        dreq           = '0;
        mul_a          = D2_W'(dx_reg);
        emit           = 1'b0;
        emit_x         = rd_x;
        emit_y         = rd_y;
        emit_end       = 1'b0;
        emit_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    take          = 1'b1;
                    op_next       = head.cmd.op;
                    px_next       = head.cmd.x;
                    py_next       = head.cmd.y;
                    ap_x_next     = head.cmd.x;
                    ap_y_next     = head.cmd.y;
                    ap_final_next = 1'b1;
                    fl_idx_next   = '0;
                    case (head.cmd.op)
                        REQ_DOWN:
                        begin
                            committed_next = 1'b1;
                            ap_ret_next    = S_IDLE;
                            state_next     = (held_reg != '0) ? S_FLUSH : S_APPEND;
                        end
                        REQ_CANCEL:
                        begin
                            held_next = '0;
                        end
                        REQ_MOVE:
                        begin
                            if (committed_reg)
                            begin
                                committed_next = 1'b0;
                                ap_ret_next    = S_SMSTART;
                                state_next     = S_APPEND;
                            end
                            else if (held_reg > HW'(1))
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        REQ_UP:
                        begin
                            if (held_reg != '0)
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_end  = flush_end;
                    emit_last = flush_end;
                    if (flush_end)
                    begin
                        held_next  = '0;
                        state_next = (op_reg == REQ_DOWN) ? S_APPEND : S_IDLE;
                    end
                    else
                    begin
                        fl_idx_next = fl_idx_reg + 1'b1;
                    end
                end
            end
            S_APPEND:
            begin
                if (held_reg == HW'(WP))
                begin
                    // full window: the oldest point leaves, marked last only when the appended point is final
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_x    = win_x_reg[0];
                        emit_y    = win_y_reg[0];
                        emit_last = ap_final_reg;
                        for (int k = 0; k < WP - 1; k++)
                        begin
                            win_x_next[k] = win_x_reg[k + 1];
                            win_y_next[k] = win_y_reg[k + 1];
                        end
                        win_x_next[WP-1] = ap_x_reg;
                        win_y_next[WP-1] = ap_y_reg;
                        state_next       = ap_ret_reg;
                    end
                end
                else
                begin
                    win_x_next[held_reg[IW-1:0]] = ap_x_reg;
                    win_y_next[held_reg[IW-1:0]] = ap_y_reg;
                    held_next                    = held_reg + 1'b1;
                    state_next                   = ap_ret_reg;
                end
            end
            S_LOAD:
            begin
                x0_next             = rd_x;
                y0_next             = rd_y;
                dx_next             = {px_reg[COORD_W-1], px_reg} - {rd_x[COORD_W-1], rd_x};
                dy_next             = {py_reg[COORD_W-1], py_reg} - {rd_y[COORD_W-1], rd_y};
                win_x_next[last_ix] = px_reg;
                win_y_next[last_ix] = py_reg;
                state_next          = S_SQX;
            end
            S_SQX:
            begin
                mul_a      = D2_W'(dx_reg);
                d2_next    = D2_W'($unsigned(mul_p));
                state_next = S_SQY;
            end
            S_SQY:
            begin
                mul_a      = D2_W'(dy_reg);
                d2_next    = d2_reg + D2_W'($unsigned(mul_p));
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (d2_reg > SPLIT_D2)
                begin
                    c_next     = c_calc;
                    seg_i_next = CW'(1);
                    accx_next  = DIV_W'(mdx);
                    accy_next  = DIV_W'(mdy);
                    state_next = S_SEGDIV;
                end
                else
                begin
                    state_next = S_SMSTART;
                end
            end
            S_SEGDIV:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = DEN_W'(c_reg);
                dreq.num_x   = accx_reg;
                dreq.num_y   = accy_reg;
                state_next   = S_SEGWAIT;
            end
            S_SEGWAIT:
            begin
                if (drsp.done)
                begin
                    if (seg_i_reg == CW'(1))
                    begin
                        // first segment point replaces the provisional one
                        win_x_next[last_ix] = $signed(seg_x);
                        win_y_next[last_ix] = $signed(seg_y);
                        state_next          = S_SEGNEXT;
                    end
                    else
                    begin
                        ap_x_next     = $signed(seg_x);
                        ap_y_next     = $signed(seg_y);
                        ap_final_next = 1'b0;
                        ap_ret_next   = S_SEGNEXT;
                        state_next    = S_APPEND;
                    end
                end
            end
            S_SEGNEXT:
            begin
                seg_i_next = seg_i_reg + 1'b1;
                accx_next  = accx_reg + DIV_W'(mdx);
                accy_next  = accy_reg + DIV_W'(mdy);
                if (seg_i_reg + CW'(1) == c_reg)
                begin
                    ap_x_next      = px_reg;
                    ap_y_next      = py_reg;
                    ap_final_next  = 1'b1;
                    ap_ret_next    = S_SMSTART;
                    committed_next = 1'b1;
                    state_next     = S_APPEND;
                end
                else
                begin
                    state_next = S_SEGDIV;
                end
            end
            S_SMSTART:
            begin
                if (held_reg == HW'(WP))
                begin
                    sm_i_next  = IW'(1);
                    tap_next   = '0;
                    sumx_next  = '0;
                    sumy_next  = '0;
                    den_next   = '0;
                    state_next = S_SMTAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SMTAP:
            begin
                sumx_next = sumx_reg + w_s * rdx_e;
                sumy_next = sumy_reg + w_s * rdy_e;
                den_next  = den_reg + DEN_W'(w);
                if (tap_reg == tap_end)
                begin
                    state_next = S_SMDIV;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_SMDIV:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = den_reg;
                dreq.num_x   = sumx_reg[SUM_W-1] ? negsum_x[DIV_W-1:0] : sumx_reg[DIV_W-1:0];
                dreq.num_y   = sumy_reg[SUM_W-1] ? negsum_y[DIV_W-1:0] : sumy_reg[DIV_W-1:0];
                state_next   = S_SMWAIT;
            end
            S_SMWAIT:
            begin
                if (drsp.done)
                begin
                    sm_x_next[sm_i_reg] = $signed(smv_x);
                    sm_y_next[sm_i_reg] = $signed(smv_y);
                    if (sm_i_reg == IW'(WP - 2))
                    begin
                        state_next = S_SMCOPY;
                    end
                    else
                    begin
                        sm_i_next  = sm_i_reg + 1'b1;
                        tap_next   = (sm_i_reg >= IW'(2)) ? (sm_i_reg - IW'(2)) : '0;
                        sumx_next  = '0;
                        sumy_next  = '0;
                        den_next   = '0;
                        state_next = S_SMTAP;
                    end
                end
            end
            S_SMCOPY:
            begin
                for (int k = 1; k < WP - 1; k++)
                begin
                    win_x_next[k] = sm_x_reg[k];
                    win_y_next[k] = sm_y_reg[k];
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (point.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ap_ret_reg    <= S_IDLE;
            held_reg      <= '0;
            committed_reg <= 1'b0;
            fl_idx_reg    <= '0;
            c_reg         <= '0;
            seg_i_reg     <= '0;
            sm_i_reg      <= '0;
            tap_reg       <= '0;
            ap_final_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ap_ret_reg    <= ap_ret_next;
            held_reg      <= held_next;
            committed_reg <= committed_next;
            fl_idx_reg    <= fl_idx_next;
            c_reg         <= c_next;
            seg_i_reg     <= seg_i_next;
            sm_i_reg      <= sm_i_next;
            tap_reg       <= tap_next;
            ap_final_reg  <= ap_final_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_x_reg <= win_x_next;
        win_y_reg <= win_y_next;
        sm_x_reg  <= sm_x_next;
        sm_y_reg  <= sm_y_next;
        op_reg    <= op_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        d2_reg    <= d2_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        ap_x_reg  <= ap_x_next;
        ap_y_reg  <= ap_y_next;
        sumx_reg  <= sumx_next;
        sumy_reg  <= sumy_next;
        den_reg   <= den_next;
        if (emit)
        begin
            ox_reg    <= emit_x;
            oy_reg    <= emit_y;
            oend_reg  <= emit_end;
            olast_reg <= emit_last;
        end
    end

endmodule

// ===== rtl/touch_stroke_smoother_unit.sv =====
// touch stroke smoother top level
//
// channel  dir  handshake    payload
// touch    in   valid/ready  req_type[1:0], in_x[15:0], in_y[15:0]
// point    out  valid/ready  out_x[15:0], out_y[15:0], stroke_end, last
//
// with a full window each move runs a smoothing pass over the inner points,
// bounded by the shared bit-serial divider that serves each smoothed point in
// turn, and each inserted segment takes one more divider run; flushes emit one
// point per cycle while the output is not stalled
// reset clears the point count and flags at once, no clearing pass
// intake takes requests into a two-entry queue while output is stalled, until it is full
module touch_stroke_smoother_unit import tsm_pkg::*;
#(
    parameter int WINDOW_POINTS = 8,
    parameter int MAX_SEGMENTS  = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    tsm_in_if.sink    touch,
    tsm_out_if.source point
);

    q_push_t  push;
    logic     full;
    q_pop_t   head;
    logic     take;
    div_req_t dreq;
    div_rsp_t drsp;

    tsm_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .touch (touch),
        .push  (push),
        .full  (full)
    );

    tsm_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .take  (take)
    );

    tsm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    tsm_back #(
        .WINDOW_POINTS (WINDOW_POINTS),
        .MAX_SEGMENTS  (MAX_SEGMENTS)
    ) u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .take  (take),
        .dreq  (dreq),
        .drsp  (drsp),
        .point (point)
    );

endmodule

// ===== rtl/tsm_checker.sv =====
// port-level checks for the touch stroke smoother, bound to the top level
`include "touch_stroke_smoother_unit_macros.svh"

module tsm_checker
(
    input logic       clk,
    input logic       rst_n,
    tsm_in_if.sink    touch,
    tsm_out_if.source point
);

    `TSM_ASSERT_NEXT(a_valid_hold, point.valid && !point.ready, point.valid, "point request dropped while stalled")
    `TSM_ASSERT_NEXT(a_payload_hold, point.valid && !point.ready, $stable(point.out_x) && $stable(point.out_y) && $stable(point.stroke_end) && $stable(point.last), "point payload changed while stalled")
    `TSM_ASSERT_NOW(a_end_is_last, point.valid && point.stroke_end, point.last, "stroke end without last")

endmodule

bind touch_stroke_smoother_unit tsm_checker u_tsm_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .touch (touch),
    .point (point)
);
